// ----- rtl/core/fifo_writeback_buffer_pool_top_macros.svh -----
// assertion macros used by the buffer pool checker
`ifndef FIFO_WRITEBACK_BUFFER_POOL_TOP_MACROS_SVH
`define FIFO_WRITEBACK_BUFFER_POOL_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fbp_pkg.sv -----
// shared types, constants and helpers of the buffer pool
package fbp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int ID_BITS    = 16;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int LIMIT_W    = 5;
  localparam int OPC_W      = 2;

  localparam logic [OPC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPC_W-1:0] OP_MARK   = 2'd2;
  localparam logic [OPC_W-1:0] OP_FLUSH  = 2'd3;

  localparam logic [1:0] REG_POOL_LIMIT = 2'd0;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WB     = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_NEXT,
    CELL_TAKE_WRAP,
    CELL_LOAD,
    CELL_SET_DIRTY
  } cell_cmd_t;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_SET_DIRTY,
    CH_APPEND,
    CH_EVICT_APPEND,
    CH_ROTATE
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t        mode;
    logic [ID_BITS-1:0] key;
    logic               new_dirty;
    logic [CNT_W-1:0]   count;
  } chain_ctl_t;

  typedef struct packed {
    logic               hit;
    logic [ID_BITS-1:0] head_id;
    logic               head_dirty;
  } chain_stat_t;

  typedef struct packed {
    logic               kind;
    logic [ID_BITS-1:0] id;
    logic               hit;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

  function automatic res_t mk_status(logic [ID_BITS-1:0] id, logic hit,
                                     logic [CNT_W-1:0] count);
    res_t r;
    r.kind  = KIND_STATUS;
    r.id    = id;
    r.hit   = hit;
    r.count = count;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_wb(logic [ID_BITS-1:0] id);
    res_t r;
    r.kind  = KIND_WB;
    r.id    = id;
    r.hit   = 1'b0;
    r.count = '0;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/core/fbp_cell.sv -----
// one queue cell: block id, dirty mark and id compare
module fbp_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbp_pkg::cell_cmd_t          cmd,
  input  logic [fbp_pkg::ID_BITS-1:0] next_id,
  input  logic                        next_dirty,
  input  logic [fbp_pkg::ID_BITS-1:0] wrap_id,
  input  logic [fbp_pkg::ID_BITS-1:0] key,
  input  logic                        new_dirty,
  output logic [fbp_pkg::ID_BITS-1:0] cell_id,
  output logic                        cell_dirty,
  output logic                        match
);

  logic [fbp_pkg::ID_BITS-1:0] id_r, id_nxt;
  logic                        dirty_r, dirty_nxt;

  always_comb begin
    id_nxt    = id_r;
    dirty_nxt = dirty_r;
    case (cmd)
      fbp_pkg::CELL_TAKE_NEXT: begin
        id_nxt    = next_id;
        dirty_nxt = next_dirty;
      end
      // oldest word comes around to the tail with its mark cleared
      fbp_pkg::CELL_TAKE_WRAP: begin
        id_nxt    = wrap_id;
        dirty_nxt = 1'b0;
      end
      fbp_pkg::CELL_LOAD: begin
        id_nxt    = key;
        dirty_nxt = new_dirty;
      end
      fbp_pkg::CELL_SET_DIRTY: dirty_nxt = new_dirty;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (!rst_n) begin
      dirty_r <= 1'b0;
    end else begin
      dirty_r <= dirty_nxt;
    end
  end

  assign cell_id    = id_r;
  assign cell_dirty = dirty_r;
  assign match      = (id_r == key);

endmodule

// ----- rtl/core/fbp_chain.sv -----
// row of queue cells, oldest entry in cell 0
module fbp_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fbp_pkg::chain_ctl_t  ctl,
  output fbp_pkg::chain_stat_t stat
);

  logic [fbp_pkg::ID_BITS-1:0] ids   [fbp_pkg::POOL_DEPTH];
  logic                        dirty [fbp_pkg::POOL_DEPTH];
  logic [fbp_pkg::POOL_DEPTH-1:0] match_vec;
  logic [fbp_pkg::POOL_DEPTH-1:0] valid_vec;
  logic [fbp_pkg::CNT_W-1:0]      tail_idx;

  assign tail_idx = ctl.count - 1'b1;

  for (genvar i = 0; i < fbp_pkg::POOL_DEPTH; i++) begin : g_cell
    fbp_pkg::cell_cmd_t          cmd;
    logic [fbp_pkg::ID_BITS-1:0] nb_id;
    logic                        nb_dirty;
    logic                        m;

    assign valid_vec[i] = (fbp_pkg::CNT_W'(i) < ctl.count);

    always_comb begin
      cmd = fbp_pkg::CELL_HOLD;
      case (ctl.mode)
        fbp_pkg::CH_SET_DIRTY:
          if (m && valid_vec[i]) cmd = fbp_pkg::CELL_SET_DIRTY;
        fbp_pkg::CH_APPEND:
          if (fbp_pkg::CNT_W'(i) == ctl.count) cmd = fbp_pkg::CELL_LOAD;
        fbp_pkg::CH_EVICT_APPEND: begin
          if (fbp_pkg::CNT_W'(i) < tail_idx) cmd = fbp_pkg::CELL_TAKE_NEXT;
          else if (fbp_pkg::CNT_W'(i) == tail_idx) cmd = fbp_pkg::CELL_LOAD;
        end
        fbp_pkg::CH_ROTATE: begin
          if (fbp_pkg::CNT_W'(i) < tail_idx) cmd = fbp_pkg::CELL_TAKE_NEXT;
          else if (fbp_pkg::CNT_W'(i) == tail_idx) cmd = fbp_pkg::CELL_TAKE_WRAP;
        end
        default: ;
      endcase
    end

    // the last cell never shifts, its neighbor input is unused
    if (i == fbp_pkg::POOL_DEPTH - 1) begin : g_end
      assign nb_id    = ctl.key;
      assign nb_dirty = 1'b0;
    end else begin : g_mid
      assign nb_id    = ids[i+1];
      assign nb_dirty = dirty[i+1];
    end

    fbp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .next_id    (nb_id),
      .next_dirty (nb_dirty),
      .wrap_id    (ids[0]),
      .key        (ctl.key),
      .new_dirty  (ctl.new_dirty),
      .cell_id    (ids[i]),
      .cell_dirty (dirty[i]),
      .match      (m)
    );

    assign match_vec[i] = m;
  end

  assign stat.hit        = |(match_vec & valid_vec);
  assign stat.head_id    = ids[0];
  assign stat.head_dirty = dirty[0];

endmodule

// ----- rtl/core/fifo_writeback_buffer_pool_top.sv -----
// fifo write-back buffer pool: control sequencer, config register, result register
// lookup, mark dirty, add: done in EXEC, status word registered from it, busy until it shows
// add evicting a dirty entry: write-back word registered from EXEC, status from STATUS after it
// flush: one rotation step per held entry, write-backs oldest first, then the status word;
//   busy until the status word shows; results are never held off
// synchronous reset empties the pool, clears all dirty marks and sets pool_limit to 16
module fifo_writeback_buffer_pool_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fbp_pkg::OPC_W-1:0]     in_opcode,
  input  logic [fbp_pkg::ID_BITS-1:0]   in_block_id,
  input  logic                          in_initial_dirty,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic [fbp_pkg::ID_BITS-1:0]   out_block_id,
  output logic                          out_hit,
  output logic [fbp_pkg::CNT_W-1:0]     out_entry_count,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STATUS,
    ST_FLUSH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [fbp_pkg::OPC_W-1:0]       op_r, op_nxt;
  logic [fbp_pkg::ID_BITS-1:0]     key_r, key_nxt;
  logic                            init_dirty_r, init_dirty_nxt;
  logic [fbp_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [fbp_pkg::CNT_W-1:0]       flush_k_r, flush_k_nxt;
  logic [fbp_pkg::LIMIT_W-1:0]     pool_limit_r;
  logic                            strobe_r, strobe_nxt;
  fbp_pkg::res_t                   res_r, res_nxt;
  logic [fbp_pkg::CNT_W-1:0]       lim;
  logic                            evict;
  fbp_pkg::chain_ctl_t             ctl;
  fbp_pkg::chain_stat_t            stat;

  // config register, single word so every address maps to it
  assign pready = 1'b1;
  assign prdata = 32'(pool_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_limit_r <= fbp_pkg::LIMIT_W'(16);
    end else if (psel && penable && pwrite) begin
      pool_limit_r <= pwdata[fbp_pkg::LIMIT_W-1:0];
    end
  end

  // limit clamped into 1..depth
  always_comb begin
    if (pool_limit_r == '0) lim = fbp_pkg::CNT_W'(1);
    else if (32'(pool_limit_r) > fbp_pkg::POOL_DEPTH)
      lim = fbp_pkg::CNT_W'(fbp_pkg::POOL_DEPTH);
    else lim = fbp_pkg::CNT_W'(pool_limit_r);
  end

  assign evict = (count_r >= lim) && (count_r != '0);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    init_dirty_nxt = init_dirty_r;
    count_nxt      = count_r;
    flush_k_nxt    = flush_k_r;
    strobe_nxt     = 1'b0;
    res_nxt        = res_r;
    ctl.mode       = fbp_pkg::CH_HOLD;
    ctl.key        = key_r;
    ctl.new_dirty  = init_dirty_r;
    ctl.count      = count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt         = in_opcode;
          key_nxt        = in_block_id;
          init_dirty_nxt = in_initial_dirty;
          state_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        case (op_r)
          fbp_pkg::OP_ADD: begin
            if (stat.hit) begin
              ctl.mode = fbp_pkg::CH_SET_DIRTY;
              res_nxt  = fbp_pkg::mk_status(key_r, 1'b1, count_r);
            end else if (evict) begin
              // drop the head, new id lands at the old tail position
              ctl.mode = fbp_pkg::CH_EVICT_APPEND;
              if (stat.head_dirty) begin
                res_nxt   = fbp_pkg::mk_wb(stat.head_id);
                state_nxt = ST_STATUS;
              end else begin
                res_nxt = fbp_pkg::mk_status(key_r, 1'b0, count_r);
              end
            end else begin
              ctl.mode  = fbp_pkg::CH_APPEND;
              count_nxt = count_r + 1'b1;
              res_nxt   = fbp_pkg::mk_status(key_r, 1'b0, count_nxt);
            end
          end
          fbp_pkg::OP_LOOKUP: begin
            res_nxt = fbp_pkg::mk_status(key_r, stat.hit, count_r);
          end
          fbp_pkg::OP_MARK: begin
            ctl.new_dirty = 1'b1;
            if (stat.hit) ctl.mode = fbp_pkg::CH_SET_DIRTY;
            res_nxt = fbp_pkg::mk_status(key_r, stat.hit, count_r);
          end
          default: begin
            strobe_nxt  = 1'b0;
            flush_k_nxt = '0;
            state_nxt   = ST_FLUSH;
          end
        endcase
      end
      ST_STATUS: begin
        strobe_nxt = 1'b1;
        res_nxt    = fbp_pkg::mk_status(key_r, 1'b0, count_r);
        state_nxt  = ST_IDLE;
      end
      ST_FLUSH: begin
        if (flush_k_r == count_r) begin
          strobe_nxt = 1'b1;
          res_nxt    = fbp_pkg::mk_status('0, 1'b0, count_r);
          state_nxt  = ST_IDLE;
        end else begin
          // rotate once per held entry so the row ends in its original order
          ctl.mode    = fbp_pkg::CH_ROTATE;
          flush_k_nxt = flush_k_r + 1'b1;
          if (stat.head_dirty) begin
            strobe_nxt = 1'b1;
            res_nxt    = fbp_pkg::mk_wb(stat.head_id);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    init_dirty_r <= init_dirty_nxt;
    flush_k_r    <= flush_k_nxt;
    res_r        <= res_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  fbp_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_kind        = res_r.kind;
  assign out_block_id    = res_r.id;
  assign out_hit         = res_r.hit;
  assign out_entry_count = res_r.count;
  assign out_last        = res_r.last;

endmodule

// ----- rtl/core/fbp_checker.sv -----
// port-level checks of the buffer pool, bound to the top level
`include "fifo_writeback_buffer_pool_top_macros.svh"

module fbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic                        out_kind,
  input logic                        out_hit,
  input logic [fbp_pkg::CNT_W-1:0]   out_entry_count,
  input logic                        out_last
);

  // status word closes every item, write-backs never do
  `FBP_ASSERT_NOW(a_last_is_status, out_strobe, out_kind != out_last, "last and kind disagree")
  `FBP_ASSERT_NOW(a_wb_fields_zero, out_strobe && out_kind,
                  !out_hit && out_entry_count == '0, "write-back carries status fields")
  `FBP_ASSERT_NOW(a_status_frees, out_strobe && out_last, !busy, "still busy after the status word")
  `FBP_ASSERT_NOW(a_wb_while_busy, out_strobe && !out_last, busy, "write-back with no item in work")
  `FBP_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_strobe,
                   "accepted word did not raise busy")

endmodule

bind fifo_writeback_buffer_pool_top fbp_checker u_fbp_checker (.*);

// ----- test/tb_top.sv -----
// testbench for the fifo write-back buffer pool: directed and random commands, scoreboard check
module tb_top;
  import fbp_pkg::*;

  class buffer_pool_model;
    logic [ID_BITS-1:0] ring_id [POOL_DEPTH];
    logic               ring_dirty [POOL_DEPTH];
    int                 head;
    int                 held;
    int                 pool_limit;
    int                 errors;
    res_t               pending[$];

    function new();
      head = 0;
      held = 0;
      pool_limit = 16;
      errors = 0;
      foreach (ring_dirty[i]) begin
        ring_dirty[i] = 1'b0;
        ring_id[i] = '0;
      end
    endfunction

    function int find_slot(logic [ID_BITS-1:0] id);
      int s;
      for (int k = 0; k < held; k++) begin
        s = (head + k) % POOL_DEPTH;
        if (ring_id[s] == id) return s;
      end
      return -1;
    endfunction

    function void push_result(logic kind, logic [ID_BITS-1:0] id, logic hit,
                              logic [CNT_W-1:0] count, logic lst);
      res_t r;
      r.kind  = kind;
      r.id    = id;
      r.hit   = hit;
      r.count = count;
      r.last  = lst;
      pending = {pending, r};
    endfunction

    // predicts the write-backs and the status caused by one accepted command
    function void apply_command(logic [OPC_W-1:0] op, logic [ID_BITS-1:0] id, logic dirty);
      int  s;
      int  lim;
      logic hit;
      hit = 1'b0;
      s = find_slot(id);
      case (op)
        OP_ADD: begin
          if (s >= 0) begin
            hit = 1'b1;
            ring_dirty[s] = dirty;
          end else begin
            lim = (pool_limit < 1) ? 1 : (pool_limit > POOL_DEPTH) ? POOL_DEPTH : pool_limit;
            // only one eviction per add, even when the limit dropped below the count
            if (held >= lim && held > 0) begin
              if (ring_dirty[head]) push_result(KIND_WB, ring_id[head], 1'b0, '0, 1'b0);
              ring_dirty[head] = 1'b0;
              head = (head + 1) % POOL_DEPTH;
              held--;
            end
            if (held < POOL_DEPTH) begin
              s = (head + held) % POOL_DEPTH;
              ring_id[s] = id;
              ring_dirty[s] = dirty;
              held++;
            end
          end
          push_result(KIND_STATUS, id, hit, CNT_W'(held), 1'b1);
        end
        OP_LOOKUP: begin
          hit = (s >= 0);
          push_result(KIND_STATUS, id, hit, CNT_W'(held), 1'b1);
        end
        OP_MARK: begin
          if (s >= 0) begin
            hit = 1'b1;
            ring_dirty[s] = 1'b1;
          end
          push_result(KIND_STATUS, id, hit, CNT_W'(held), 1'b1);
        end
        default: begin
          for (int k = 0; k < held; k++) begin
            s = (head + k) % POOL_DEPTH;
            if (ring_dirty[s]) begin
              push_result(KIND_WB, ring_id[s], 1'b0, '0, 1'b0);
              ring_dirty[s] = 1'b0;
            end
          end
          push_result(KIND_STATUS, '0, 1'b0, CNT_W'(held), 1'b1);
        end
      endcase
    endfunction

    function void match_result(logic kind, logic [ID_BITS-1:0] id, logic hit,
                               logic [CNT_W-1:0] count, logic lst);
      res_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: kind %0d id %h", kind, id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (id !== e.id) begin
        $error("out_block_id: expected %h, got %h", e.id, id);
        errors++;
      end
      if (hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, hit);
        errors++;
      end
      if (count !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, count);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OPC_W-1:0]   in_opcode;
  logic [ID_BITS-1:0] in_block_id;
  logic               in_initial_dirty;
  logic               out_strobe;
  logic               out_kind;
  logic [ID_BITS-1:0] out_block_id;
  logic               out_hit;
  logic [CNT_W-1:0]   out_entry_count;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  buffer_pool_model pool = new();
  int idle_pct;

  fifo_writeback_buffer_pool_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_block_id      (in_block_id),
    .in_initial_dirty (in_initial_dirty),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_block_id     (out_block_id),
    .out_hit          (out_hit),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // results first, then the word taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        pool.match_result(out_kind, out_block_id, out_hit, out_entry_count, out_last);
      if (start && !busy)
        pool.apply_command(in_opcode, in_block_id, in_initial_dirty);
    end
  end

  task automatic send_word(logic [OPC_W-1:0] op, logic [ID_BITS-1:0] id, logic dirty);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_opcode = op;
    in_block_id = id;
    in_initial_dirty = dirty;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk);
    start = 1'b0;
    while (pool.pending.size() != 0 || busy) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_POOL_LIMIT;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool.pool_limit = value & 32'h1f;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (prdata !== (value & 32'h1f)) begin
      $error("prdata: expected %0d, got %0d", value & 32'h1f, prdata);
      pool.errors++;
    end
  endtask

  initial begin
    logic [ID_BITS-1:0] id_set [40];
    int                 phase_limit [8] = '{1, 16, 31, 0, 3, 12, 16, 2};
    int                 phase_idle [8]  = '{0, 62, 12, 62, 0, 62, 12, 0};
    logic [OPC_W-1:0]   op;
    logic [ID_BITS-1:0] id;
    int                 r;

    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_block_id = '0;
    in_initial_dirty = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_POOL_LIMIT;
    pwdata = '0;
    idle_pct = 0;
    foreach (id_set[i]) id_set[i] = ID_BITS'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset limit of 16
    send_word(OP_ADD, 16'hffff, 1'b1);
    send_word(OP_ADD, 16'h0000, 1'b0);
    send_word(OP_LOOKUP, 16'hffff, 1'b0);
    send_word(OP_LOOKUP, 16'h1234, 1'b1);
    send_word(OP_MARK, 16'h0000, 1'b0);
    send_word(OP_MARK, 16'h5555, 1'b1);
    send_word(OP_ADD, 16'hffff, 1'b0);   // re-add clears the mark in place
    send_word(OP_FLUSH, 16'h0000, 1'b0);
    send_word(OP_FLUSH, 16'h0000, 1'b0); // nothing dirty left
    send_word(OP_ADD, 16'h0001, 1'b1);
    send_word(OP_ADD, 16'h0002, 1'b1);
    send_word(OP_ADD, 16'h0003, 1'b0);
    send_word(OP_ADD, 16'h0004, 1'b1);
    wait_drained(4);
    write_limit(32'd2);                  // now below the held count
    send_word(OP_ADD, 16'haaaa, 1'b1);
    send_word(OP_ADD, 16'h5555, 1'b1);
    send_word(OP_LOOKUP, 16'hffff, 1'b0);
    send_word(OP_FLUSH, 16'hffff, 1'b1);
    send_word(OP_ADD, 16'h0001, 1'b0);
    wait_drained(4);
    write_limit(32'd0);                  // zero behaves as one
    send_word(OP_ADD, 16'h00f0, 1'b1);
    send_word(OP_ADD, 16'h0f00, 1'b0);
    send_word(OP_MARK, 16'h0f00, 1'b0);
    send_word(OP_FLUSH, 16'h1111, 1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_drained(4);
      write_limit(phase_limit[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < 25; n++) begin
        r = $urandom_range(99);
        op = (r < 50) ? OP_ADD : (r < 65) ? OP_LOOKUP : (r < 88) ? OP_MARK : OP_FLUSH;
        id = ($urandom_range(99) < 75) ? id_set[$urandom_range(39)] : ID_BITS'($urandom);
        send_word(op, id, 1'($urandom));
        if ($urandom_range(99) < 4) wait_drained(0);
      end
    end

    wait_drained(20);
    if (pool.pending.size() != 0) begin
      $error("%0d expected result words never arrived", pool.pending.size());
      pool.errors++;
    end
    if (pool.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
